// ----- hdl/lsha_pkg.sv -----
// Shared types, codes and defaults for the limit switch with hysteresis and alarm unit.
// No dependencies; the register file, controller, datapath and top level take names from here by scope.
package lsha_pkg;

    // Default parameter values
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int COUNT_MODULUS_DEF = 10000;

    // Register map
    localparam int NUM_REGS  = 7;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_IS_LOW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_ON     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ALARM_MODE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_MIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_MAX    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS   = 3'd6;

    typedef enum logic [1:0] {
        VM_RAW   = 2'd0,
        VM_DIFF  = 2'd1,
        VM_DIV   = 2'd2,
        VM_UNDEF = 2'd3
    } lsha_value_mode_t;

    typedef enum logic [2:0] {
        AM_LEVEL   = 3'd0,
        AM_INVERSE = 3'd1,
        AM_RISE    = 3'd2,
        AM_FALL    = 3'd3,
        AM_BOTH    = 3'd4
    } lsha_alarm_mode_t;

    typedef struct packed {
        lsha_value_mode_t value_mode;
        logic             limit_is_low;
        logic             alarm_on;
        logic [2:0]       alarm_mode;
    } lsha_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_EVAL   = 2'd2,
        ST_COMMIT = 2'd3
    } lsha_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic eval;
        logic commit;
    } lsha_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } lsha_status_t;

endpackage

// ----- hdl/lsha_in_if.sv -----
// Input channel interface: valid/ready handshake plus one tick's sample fields.
// Depends on nothing; width follows DW.
interface lsha_in_if #(
    parameter int DW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 enable;
    logic signed [DW-1:0] process_value;
    logic signed [DW-1:0] reference_value;
    logic signed [DW-1:0] limit_value;

    modport source (
        output valid, enable, process_value, reference_value, limit_value,
        input  ready
    );
    modport sink (
        input  valid, enable, process_value, reference_value, limit_value,
        output ready
    );
endinterface

// ----- hdl/lsha_out_if.sv -----
// Result channel interface: valid/ready handshake plus one tick's result fields.
// Depends on nothing; widths follow DW and CW.
interface lsha_out_if #(
    parameter int DW = 32,
    parameter int CW = 14
);
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic                 violation;
    logic                 alarm;
    logic signed [DW-1:0] modified_value;
    logic [CW-1:0]        tick_count;

    modport source (
        output valid, ok, violation, alarm, modified_value, tick_count,
        input  ready
    );
    modport sink (
        input  valid, ok, violation, alarm, modified_value, tick_count,
        output ready
    );
endinterface

// ----- hdl/lsha_regs.sv -----
// APB-style configuration register file: mode fields, limit window and hysteresis.
// Depends on lsha_pkg.
module lsha_regs #(
    parameter int DW = lsha_pkg::DATA_WIDTH_DEF,
    parameter int PW = 32,
    parameter int AW = 5,
    parameter int SL = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [PW-1:0]        pwdata,
    output logic [PW-1:0]        prdata,
    output lsha_pkg::lsha_mode_t mode,
    output logic signed [DW-1:0] limit_min,
    output logic signed [DW-1:0] limit_max,
    output logic signed [DW-1:0] hysteresis
);

    localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};

    lsha_pkg::lsha_mode_t        mode_reg;
    logic signed [DW-1:0]        limit_min_reg;
    logic signed [DW-1:0]        limit_max_reg;
    logic signed [DW-1:0]        hysteresis_reg;
    logic [lsha_pkg::REG_IDX_W-1:0] idx;
    logic                        wr_en;

    assign idx   = lsha_pkg::REG_IDX_W'(paddr[AW-1:SL]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg.value_mode   <= lsha_pkg::VM_RAW;
            mode_reg.limit_is_low <= 1'b0;
            mode_reg.alarm_on     <= 1'b0;
            mode_reg.alarm_mode   <= 3'd0;
            limit_min_reg         <= WMIN;
            limit_max_reg         <= WMAX;
            hysteresis_reg        <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                lsha_pkg::REG_VALUE_MODE:
                    mode_reg.value_mode <= lsha_pkg::lsha_value_mode_t'(pwdata[1:0]);
                lsha_pkg::REG_LIMIT_IS_LOW: mode_reg.limit_is_low <= pwdata[0];
                lsha_pkg::REG_ALARM_ON:     mode_reg.alarm_on     <= pwdata[0];
                lsha_pkg::REG_ALARM_MODE:   mode_reg.alarm_mode   <= pwdata[2:0];
                lsha_pkg::REG_LIMIT_MIN:    limit_min_reg         <= pwdata[DW-1:0];
                lsha_pkg::REG_LIMIT_MAX:    limit_max_reg         <= pwdata[DW-1:0];
                lsha_pkg::REG_HYSTERESIS:   hysteresis_reg        <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lsha_pkg::REG_VALUE_MODE:   prdata = PW'(mode_reg.value_mode);
            lsha_pkg::REG_LIMIT_IS_LOW: prdata = PW'(mode_reg.limit_is_low);
            lsha_pkg::REG_ALARM_ON:     prdata = PW'(mode_reg.alarm_on);
            lsha_pkg::REG_ALARM_MODE:   prdata = PW'(mode_reg.alarm_mode);
            lsha_pkg::REG_LIMIT_MIN:    prdata = PW'(unsigned'(limit_min_reg));
            lsha_pkg::REG_LIMIT_MAX:    prdata = PW'(unsigned'(limit_max_reg));
            lsha_pkg::REG_HYSTERESIS:   prdata = PW'(unsigned'(hysteresis_reg));
            default:                    prdata = '0;
        endcase
    end

    assign mode       = mode_reg;
    assign limit_min  = limit_min_reg;
    assign limit_max  = limit_max_reg;
    assign hysteresis = hysteresis_reg;

endmodule

// ----- hdl/lsha_ctrl.sv -----
// Controller state machine: sequences capture, division, evaluation and commit.
// Depends on lsha_pkg.
module lsha_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lsha_pkg::lsha_status_t status,
    output lsha_pkg::lsha_cmd_t    cmd
);

    lsha_pkg::lsha_state_t state_reg;
    lsha_pkg::lsha_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lsha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lsha_pkg::ST_DIVIDE;
                end
            end
            lsha_pkg::ST_DIVIDE:
            begin
                // skip straight through when no quotient is needed
                cmd.div_step = status.need_div;
                if (!status.need_div || status.div_last)
                begin
                    state_next = lsha_pkg::ST_EVAL;
                end
            end
            lsha_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = lsha_pkg::ST_COMMIT;
            end
            lsha_pkg::ST_COMMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lsha_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ----- hdl/lsha_dp.sv -----
// Datapath: operand capture, restoring divider, value forming, limit clamp,
// hysteresis switch, alarm generator, tick counter and output register. Uses lsha_pkg.
module lsha_dp #(
    parameter int DW            = lsha_pkg::DATA_WIDTH_DEF,
    parameter int FW            = lsha_pkg::FRAC_BITS_DEF,
    parameter int COUNT_MODULUS = lsha_pkg::COUNT_MODULUS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lsha_in_if.sink                sample,
    lsha_out_if.source             result,
    input  lsha_pkg::lsha_mode_t   mode,
    input  logic signed [DW-1:0]   limit_min,
    input  logic signed [DW-1:0]   limit_max,
    input  logic signed [DW-1:0]   hysteresis,
    input  lsha_pkg::lsha_cmd_t    cmd,
    output lsha_pkg::lsha_status_t status
);

    localparam int QW = DW + FW;
    localparam int SW = $clog2(QW);
    localparam int CW = $clog2(COUNT_MODULUS);

    localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QW-1:0] LIM_POS = QW'(WMAX);
    localparam logic [QW-1:0] LIM_NEG = {{(QW-1){1'b0}}, 1'b1} << (DW-1);

    // captured operands
    logic                 en_reg;
    logic signed [DW-1:0] pv_reg;
    logic signed [DW-1:0] ref_reg;
    logic signed [DW-1:0] lim_in_reg;
    logic                 neg_reg;
    logic [DW-1:0]        nd_reg;
    logic [QW-1:0]        quo_reg;
    logic [DW-1:0]        rem_reg;
    logic [SW-1:0]        step_reg;

    // evaluated values
    logic signed [DW-1:0] m_reg;
    logic signed [DW-1:0] s_reg;
    logic                 ok_reg;

    // block state
    logic signed [DW-1:0] held_mod_reg;
    logic                 prev_viol_reg;
    logic                 held_alarm_reg;
    logic [CW-1:0]        tick_reg;

    // output register
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic                 out_viol_reg;
    logic                 out_alarm_reg;
    logic signed [DW-1:0] out_mod_reg;
    logic [CW-1:0]        out_tick_reg;

    logic [DW-1:0]        pv_abs;
    logic [DW-1:0]        ref_abs;
    logic [DW:0]          trial;
    logic [DW:0]          trial_diff;
    logic                 trial_ge;
    logic [QW-1:0]        quo_next;
    logic [DW-1:0]        rem_next;

    logic [DW:0]          dif;
    logic signed [DW-1:0] sub_sat;
    logic                 over;
    logic signed [DW-1:0] div_sat;
    logic signed [DW-1:0] m_next;
    logic                 ok_next;
    logic signed [DW-1:0] s_next;

    logic signed [DW:0]   m_x;
    logic signed [DW:0]   s_x;
    logic signed [DW:0]   h_x;
    logic signed [DW:0]   bnd;
    logic                 viol_next;
    logic                 alarm_next;
    logic                 ok_out;
    logic signed [DW-1:0] held_mod_next;
    logic [CW-1:0]        tick_next;

    // magnitudes for the divider
    assign pv_abs  = sample.process_value[DW-1] ? ('0 - sample.process_value)
                                                : sample.process_value;
    assign ref_abs = sample.reference_value[DW-1] ? ('0 - sample.reference_value)
                                                  : sample.reference_value;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, quo_reg[QW-1]};
    assign trial_diff = trial - {1'b0, nd_reg};
    assign trial_ge   = ~trial_diff[DW];
    assign rem_next   = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
    assign quo_next   = {quo_reg[QW-2:0], trial_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            en_reg     <= sample.enable;
            pv_reg     <= sample.process_value;
            ref_reg    <= sample.reference_value;
            lim_in_reg <= sample.limit_value;
            neg_reg    <= sample.process_value[DW-1] ^ sample.reference_value[DW-1];
            nd_reg     <= ref_abs;
            quo_reg    <= QW'(pv_abs) << FW;
            rem_reg    <= '0;
            step_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
    end

    // value forming and limit clamp
    always_comb
    begin
        dif     = {pv_reg[DW-1], pv_reg} - {ref_reg[DW-1], ref_reg};
        sub_sat = (dif[DW] != dif[DW-1]) ? (dif[DW] ? WMIN : WMAX) : dif[DW-1:0];
        over    = neg_reg ? (quo_reg > LIM_NEG) : (quo_reg > LIM_POS);
        if (over)
        begin
            div_sat = neg_reg ? WMIN : WMAX;
        end
        else
        begin
            div_sat = neg_reg ? ('0 - quo_reg[DW-1:0]) : quo_reg[DW-1:0];
        end

        ok_next = 1'b1;
        unique case (mode.value_mode)
            lsha_pkg::VM_RAW:  m_next = pv_reg;
            lsha_pkg::VM_DIFF: m_next = sub_sat;
            lsha_pkg::VM_DIV:
            begin
                if (nd_reg == '0)
                begin
                    m_next  = '0;
                    ok_next = 1'b0;
                end
                else
                begin
                    m_next = div_sat;
                end
            end
            lsha_pkg::VM_UNDEF:
            begin
                m_next  = held_mod_reg;
                ok_next = 1'b0;
            end
        endcase

        // tested first, limit_min wins an empty window only below it; else limit_max
        if (lim_in_reg < limit_min)
        begin
            s_next = limit_min;
        end
        else if (limit_max < lim_in_reg)
        begin
            s_next = limit_max;
        end
        else
        begin
            s_next = lim_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            m_reg  <= m_next;
            s_reg  <= s_next;
            ok_reg <= ok_next;
        end
    end

    // hysteresis switch and alarm generator
    always_comb
    begin
        m_x = (DW+1)'(m_reg);
        s_x = (DW+1)'(s_reg);
        h_x = (DW+1)'(hysteresis);
        bnd = mode.limit_is_low ? (s_x + h_x) : (s_x - h_x);

        viol_next = prev_viol_reg;
        if (en_reg)
        begin
            if (mode.limit_is_low)
            begin
                if (!prev_viol_reg && (m_reg < s_reg))
                begin
                    viol_next = 1'b1;
                end
                else if (prev_viol_reg && (m_x > bnd))
                begin
                    viol_next = 1'b0;
                end
            end
            else
            begin
                if (!prev_viol_reg && (s_reg < m_reg))
                begin
                    viol_next = 1'b1;
                end
                else if (prev_viol_reg && (m_x < bnd))
                begin
                    viol_next = 1'b0;
                end
            end
        end

        ok_out     = en_reg && ok_reg;
        alarm_next = held_alarm_reg;
        if (en_reg && mode.alarm_on)
        begin
            unique case (lsha_pkg::lsha_alarm_mode_t'(mode.alarm_mode))
                lsha_pkg::AM_LEVEL:   alarm_next = viol_next;
                lsha_pkg::AM_INVERSE: alarm_next = !viol_next;
                lsha_pkg::AM_RISE:    alarm_next = viol_next && !prev_viol_reg;
                lsha_pkg::AM_FALL:    alarm_next = !viol_next && prev_viol_reg;
                lsha_pkg::AM_BOTH:    alarm_next = viol_next ^ prev_viol_reg;
                default:
                begin
                    alarm_next = 1'b0;
                    ok_out     = 1'b0;
                end
            endcase
        end

        held_mod_next = en_reg ? m_reg : held_mod_reg;
        tick_next     = (tick_reg == CW'(COUNT_MODULUS - 1)) ? '0 : tick_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mod_reg   <= '0;
            prev_viol_reg  <= 1'b0;
            held_alarm_reg <= 1'b0;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            held_mod_reg   <= held_mod_next;
            prev_viol_reg  <= viol_next;
            held_alarm_reg <= alarm_next;
            tick_reg       <= tick_next;
            out_valid_reg  <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ok_reg    <= ok_out;
            out_viol_reg  <= viol_next;
            out_alarm_reg <= alarm_next;
            out_mod_reg   <= held_mod_next;
            out_tick_reg  <= tick_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.ok             = out_ok_reg;
    assign result.violation      = out_viol_reg;
    assign result.alarm          = out_alarm_reg;
    assign result.modified_value = out_mod_reg;
    assign result.tick_count     = out_tick_reg;

    assign status.need_div = en_reg && (mode.value_mode == lsha_pkg::VM_DIV)
                             && (nd_reg != '0);
    assign status.div_last = (step_reg == SW'(QW - 1));
    assign status.out_free = !out_valid_reg || result.ready;

endmodule

// ----- hdl/limit_switch_hysteresis_alarm_unit.sv -----
// Top level of the limit switch with hysteresis and alarm unit.
// Instantiates lsha_regs, lsha_ctrl and lsha_dp; uses lsha_pkg, lsha_in_if, lsha_out_if.
//
// Each transaction on the sample channel is one control tick and yields exactly one
// transaction on the result channel. When enable is set, the process value is taken
// raw, minus the reference (saturated) or divided by the reference (Q-format quotient,
// truncated toward zero, saturated); the limit is clamped to [limit_min, limit_max],
// with limit_max winning on an empty window unless the limit lies below limit_min,
// and a low or high limit switch with hysteresis updates the violation flag. With
// alarm_on the alarm follows the flag level, its inverse, or pulses on rising,
// falling or both edges. A disabled tick only advances the tick counter, which
// wraps at COUNT_MODULUS. The block takes one tick at a time. An enabled tick in divide
// mode with a nonzero reference runs the restoring divider, which resolves one
// quotient bit per cycle in its divide state; every other tick skips the
// division. A finished result waits in the output register
// while the next tick is accepted and worked on; only its commit waits for the
// result slot. Configure through the APB-style port only while the block is idle;
// register i sits at byte address 4*i (8*i when DATA_WIDTH exceeds 32), pready is
// tied high and reads return the stored value zero-extended.
module limit_switch_hysteresis_alarm_unit #(
    parameter int  DATA_WIDTH    = lsha_pkg::DATA_WIDTH_DEF,
    parameter int  FRAC_BITS     = lsha_pkg::FRAC_BITS_DEF,
    parameter int  COUNT_MODULUS = lsha_pkg::COUNT_MODULUS_DEF,
    localparam int PW            = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int SL            = (DATA_WIDTH > 32) ? 3 : 2,
    localparam int AW            = $clog2(lsha_pkg::NUM_REGS << SL)
) (
    input  logic          clk,
    input  logic          rst_n,
    lsha_in_if.sink       sample,
    lsha_out_if.source    result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [PW-1:0] pwdata,
    output logic [PW-1:0] prdata,
    output logic          pready
);

    lsha_pkg::lsha_mode_t         mode;
    logic signed [DATA_WIDTH-1:0] limit_min;
    logic signed [DATA_WIDTH-1:0] limit_max;
    logic signed [DATA_WIDTH-1:0] hysteresis;
    lsha_pkg::lsha_cmd_t          cmd;
    lsha_pkg::lsha_status_t       status;
    logic                         in_ready;

    // zero-wait-state register port
    assign pready = 1'b1;

    lsha_regs #(
        .DW (DATA_WIDTH),
        .PW (PW),
        .AW (AW),
        .SL (SL)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .mode       (mode),
        .limit_min  (limit_min),
        .limit_max  (limit_max),
        .hysteresis (hysteresis)
    );

    // controller owns the sample-side handshake
    lsha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign sample.ready = in_ready;

    // datapath captures the sample payload and drives the result channel
    lsha_dp #(
        .DW            (DATA_WIDTH),
        .FW            (FRAC_BITS),
        .COUNT_MODULUS (COUNT_MODULUS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .result     (result),
        .mode       (mode),
        .limit_min  (limit_min),
        .limit_max  (limit_max),
        .hysteresis (hysteresis),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
